// ===== src/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer package
// Shared types, frame and status codes, retry limit and the command frame
// table (command byte, argument and precomputed CRC byte for each frame).
// ----------------------------------------------------------------------------
package sdi_pkg;

   // Number of loop passes after which an ACMD41 or CMD1 loop gives up.
   localparam int RETRY_LIMIT = 1024;
   localparam int RETRY_W     = $clog2(RETRY_LIMIT + 1);

   // Command frames that the sequencer can issue.
   localparam logic [2:0] FRAME_CMD0       = 3'd0;
   localparam logic [2:0] FRAME_CMD8       = 3'd1;
   localparam logic [2:0] FRAME_CMD55      = 3'd2;
   localparam logic [2:0] FRAME_ACMD41_HCS = 3'd3;
   localparam logic [2:0] FRAME_ACMD41     = 3'd4;
   localparam logic [2:0] FRAME_CMD1       = 3'd5;
   localparam logic [2:0] FRAME_CMD58      = 3'd6;

   // Final status codes.
   localparam logic [3:0] ST_OK             = 4'd0;
   localparam logic [3:0] ST_CMD8_NO_ANS    = 4'd1;
   localparam logic [3:0] ST_V2_CMD55_NO    = 4'd2;
   localparam logic [3:0] ST_V2_ACMD41_NO   = 4'd3;
   localparam logic [3:0] ST_V2_TIMEOUT     = 4'd4;
   localparam logic [3:0] ST_OCR_TIMEOUT    = 4'd5;
   localparam logic [3:0] ST_V1_CMD55A_NO   = 4'd6;
   localparam logic [3:0] ST_V1_ACMD41A_NO  = 4'd7;
   localparam logic [3:0] ST_V1_CMD55_NO    = 4'd8;
   localparam logic [3:0] ST_V1_ACMD41_NO   = 4'd9;
   localparam logic [3:0] ST_V1_TIMEOUT     = 4'd10;

   // One input item as held in the input register.
   typedef struct packed {
      logic       command;
      logic [7:0] response_byte;
      logic [7:0] ocr_first_byte;
      logic       ocr_timeout;
   } sdi_item_type;

   // Outcome of one item as decided by the sequencer.
   typedef struct packed {
      logic       emit;
      logic       finished;
      logic [2:0] frame;
      logic [3:0] status;
      logic       card_v2;
      logic       card_hc;
   } sdi_decision_type;

   // Fields of one command frame.
   typedef struct packed {
      logic [7:0]  command_byte;
      logic [31:0] argument;
      logic [7:0]  crc_byte;
   } sdi_frame_type;

   // CRC7 over the command byte and the four argument bytes, returned shifted
   // left with the end bit set. Evaluated at elaboration only.
   function automatic logic [7:0] crc7_frame(input logic [7:0] cmd, input logic [31:0] arg);
      logic [39:0] bits;
      logic [8:0]  crc;
      logic [9:0]  shifted;
      bits = {cmd, arg};
      crc  = '0;
      for (int b = 0; b < 5; b++) begin
         crc = crc ^ {1'b0, bits[39 - 8*b -: 8]};
         for (int k = 0; k < 8; k++) begin
            shifted = {crc, 1'b0};
            if (shifted[8]) begin
               shifted = shifted ^ 10'h012;
            end
            crc = shifted[8:0];
         end
      end
      return {crc[7:1], 1'b1};
   endfunction

   localparam logic [7:0] CRC_CMD0       = crc7_frame(8'h40, 32'h0000_0000);
   localparam logic [7:0] CRC_CMD8       = crc7_frame(8'h48, 32'h0000_01AA);
   localparam logic [7:0] CRC_CMD55      = crc7_frame(8'h77, 32'h0000_0000);
   localparam logic [7:0] CRC_ACMD41_HCS = crc7_frame(8'h69, 32'h4030_0000);
   localparam logic [7:0] CRC_ACMD41     = crc7_frame(8'h69, 32'h0000_0000);
   localparam logic [7:0] CRC_CMD1       = crc7_frame(8'h41, 32'h0000_0000);

   // Frame table lookup. CMD58 carries a fixed 0xFF in place of its CRC.
   function automatic sdi_frame_type frame_fields(input logic [2:0] frame);
      sdi_frame_type f;
      case (frame)
         FRAME_CMD0:       f = '{8'h40, 32'h0000_0000, CRC_CMD0};
         FRAME_CMD8:       f = '{8'h48, 32'h0000_01AA, CRC_CMD8};
         FRAME_CMD55:      f = '{8'h77, 32'h0000_0000, CRC_CMD55};
         FRAME_ACMD41_HCS: f = '{8'h69, 32'h4030_0000, CRC_ACMD41_HCS};
         FRAME_ACMD41:     f = '{8'h69, 32'h0000_0000, CRC_ACMD41};
         FRAME_CMD1:       f = '{8'h41, 32'h0000_0000, CRC_CMD1};
         FRAME_CMD58:      f = '{8'h7A, 32'h0000_0000, 8'hFF};
         default:          f = '0;
      endcase
      return f;
   endfunction

endpackage

// ===== src/sdi_fsm.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer state machine
// Holds the sequence state and decides, for each item, the next frame to
// send or the final status. The decision is combinational on the item.
// ----------------------------------------------------------------------------
module sdi_fsm
   import sdi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  sdi_item_type     item,
   output sdi_decision_type decision
);

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_CMD0   = 4'd1;
   localparam logic [3:0] PH_CMD8   = 4'd2;
   localparam logic [3:0] PH_V2_55  = 4'd3;
   localparam logic [3:0] PH_V2_41  = 4'd4;
   localparam logic [3:0] PH_V2_58  = 4'd5;
   localparam logic [3:0] PH_V1_55A = 4'd6;
   localparam logic [3:0] PH_V1_41A = 4'd7;
   localparam logic [3:0] PH_V1_55  = 4'd8;
   localparam logic [3:0] PH_V1_41  = 4'd9;
   localparam logic [3:0] PH_V1_C1  = 4'd10;

   localparam logic [RETRY_W-1:0] RETRY_MAX = RETRY_W'(RETRY_LIMIT);

   logic [3:0]         phase_ff, phase_in;
   logic [RETRY_W-1:0] retry_ff, retry_in;
   logic               second_try_ff, second_try_in;
   logic               kind_v2_ff, kind_v2_in;
   logic               kind_hc_ff, kind_hc_in;

   logic [RETRY_W-1:0] pass_count;
   logic               pass_timeout;
   logic               resp_none;
   logic               resp_zero;
   logic               resp_idle;

   assign resp_none    = (item.response_byte == 8'hFF);
   assign resp_zero    = (item.response_byte == 8'h00);
   assign resp_idle    = (item.response_byte == 8'h01);
   // The retry count never reaches the limit while a loop is running.
   assign pass_count   = retry_ff + 1'b1;
   assign pass_timeout = (pass_count >= RETRY_MAX);

   // Next state and outcome for the item at hand.
   always_comb begin
      phase_in      = phase_ff;
      retry_in      = retry_ff;
      second_try_in = second_try_ff;
      kind_v2_in    = kind_v2_ff;
      kind_hc_in    = kind_hc_ff;
      decision          = '0;

      if (!item.command) begin
         // Start: restart the sequence from CMD0.
         kind_v2_in    = 1'b0;
         kind_hc_in    = 1'b0;
         retry_in      = '0;
         second_try_in = 1'b0;
         decision.emit  = 1'b1;
         decision.frame = FRAME_CMD0;
         phase_in       = PH_CMD0;
      end else begin
         case (phase_ff)
            PH_CMD0: begin
               decision.emit = 1'b1;
               if (resp_idle || second_try_ff) begin
                  decision.frame = FRAME_CMD8;
                  phase_in       = PH_CMD8;
               end else begin
                  second_try_in  = 1'b1;
                  decision.frame = FRAME_CMD0;
                  phase_in       = PH_CMD0;
               end
            end
            PH_CMD8: begin
               decision.emit = 1'b1;
               if (resp_none) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_CMD8_NO_ANS;
                  phase_in          = PH_IDLE;
               end else begin
                  retry_in       = '0;
                  decision.frame = FRAME_CMD55;
                  if (item.response_byte != 8'h05) begin
                     kind_v2_in = 1'b1;
                     phase_in   = PH_V2_55;
                  end else begin
                     phase_in   = PH_V1_55A;
                  end
               end
            end
            PH_V2_55, PH_V2_41: begin
               decision.emit = 1'b1;
               if (resp_none) begin
                  decision.finished = 1'b1;
                  decision.status   = (phase_ff == PH_V2_55) ? ST_V2_CMD55_NO
                                                             : ST_V2_ACMD41_NO;
                  phase_in          = PH_IDLE;
               end else if (phase_ff == PH_V2_55 && resp_idle) begin
                  decision.frame = FRAME_ACMD41_HCS;
                  phase_in       = PH_V2_41;
               end else if (phase_ff == PH_V2_41 && resp_zero) begin
                  decision.frame = FRAME_CMD58;
                  phase_in       = PH_V2_58;
               end else begin
                  // Loop pass ended without success.
                  retry_in = pass_count;
                  if (pass_timeout) begin
                     decision.finished = 1'b1;
                     decision.status   = ST_V2_TIMEOUT;
                     phase_in          = PH_IDLE;
                  end else begin
                     decision.frame = FRAME_CMD55;
                     phase_in       = PH_V2_55;
                  end
               end
            end
            PH_V2_58: begin
               decision.emit     = 1'b1;
               decision.finished = 1'b1;
               phase_in          = PH_IDLE;
               if (item.ocr_timeout) begin
                  decision.status = ST_OCR_TIMEOUT;
               end else begin
                  decision.status = ST_OK;
                  if (item.ocr_first_byte[6]) begin
                     kind_hc_in = 1'b1;
                  end
               end
            end
            PH_V1_55A: begin
               decision.emit = 1'b1;
               if (resp_none) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_V1_CMD55A_NO;
                  phase_in          = PH_IDLE;
               end else begin
                  decision.frame = FRAME_ACMD41;
                  phase_in       = PH_V1_41A;
               end
            end
            PH_V1_41A: begin
               decision.emit = 1'b1;
               if (resp_none) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_V1_ACMD41A_NO;
                  phase_in          = PH_IDLE;
               end else begin
                  retry_in = '0;
                  if (resp_zero) begin
                     decision.frame = FRAME_CMD55;
                     phase_in       = PH_V1_55;
                  end else begin
                     decision.frame = FRAME_CMD1;
                     phase_in       = PH_V1_C1;
                  end
               end
            end
            PH_V1_55, PH_V1_41, PH_V1_C1: begin
               decision.emit = 1'b1;
               if (resp_none && phase_ff == PH_V1_55) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_V1_CMD55_NO;
                  phase_in          = PH_IDLE;
               end else if (resp_none && phase_ff == PH_V1_41) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_V1_ACMD41_NO;
                  phase_in          = PH_IDLE;
               end else if (phase_ff == PH_V1_55 && resp_idle) begin
                  decision.frame = FRAME_ACMD41;
                  phase_in       = PH_V1_41;
               end else if (phase_ff != PH_V1_55 && resp_zero) begin
                  decision.finished = 1'b1;
                  decision.status   = ST_OK;
                  phase_in          = PH_IDLE;
               end else begin
                  // Failed pass: the latest answer picks ACMD41 or CMD1 next.
                  retry_in = pass_count;
                  if (pass_timeout) begin
                     decision.finished = 1'b1;
                     decision.status   = ST_V1_TIMEOUT;
                     phase_in          = PH_IDLE;
                  end else if (resp_zero) begin
                     decision.frame = FRAME_CMD55;
                     phase_in       = PH_V1_55;
                  end else begin
                     decision.frame = FRAME_CMD1;
                     phase_in       = PH_V1_C1;
                  end
               end
            end
            default: begin
               // A response while idle is dropped.
               decision.emit = 1'b0;
            end
         endcase
      end

      decision.card_v2 = kind_v2_in;
      decision.card_hc = kind_hc_in;
   end

   // Sequence state, updated once per transfer taken from the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         retry_ff      <= '0;
         second_try_ff <= 1'b0;
         kind_v2_ff    <= 1'b0;
         kind_hc_ff    <= 1'b0;
      end else if (item_fire) begin
         phase_ff      <= phase_in;
         retry_ff      <= retry_in;
         second_try_ff <= second_try_in;
         kind_v2_ff    <= kind_v2_in;
         kind_hc_ff    <= kind_hc_in;
      end
   end

   // The retry count stays below the limit while a sequence is running.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> retry_ff < RETRY_MAX)
      else $error("retry count reached the limit without ending the loop");

   // A start transfer always leaves the sequencer waiting for the CMD0 answer.
   assert property (@(posedge clock) disable iff (reset)
      item_fire && !item.command |=> phase_ff == PH_CMD0 && !kind_v2_ff && !kind_hc_ff)
      else $error("start transfer did not restart the sequence");

   // High capacity is only reported for a version-2 card.
   assert property (@(posedge clock) disable iff (reset) kind_hc_ff |-> kind_v2_ff)
      else $error("high capacity flag set without version-2 card");

endmodule

// ===== src/sd_spi_card_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD card SPI-mode initialization sequencer
// Host-side sequencer: takes start and card-response transfers and returns
// the next command frame to send or the final status of the sequence.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while the result side is not
// stalled. An accepted transfer loads the input register, and its result
// loads the result register once that register is free or draining. The
// state machine decides combinationally between those two registers, and
// the CRC bytes come from a constant frame table, so a new transfer may
// follow every cycle while the result side is not stalled; a stalled result
// holds the input register and thus the request side. A response transfer
// that arrives while no sequence is running produces no result.
module sd_spi_card_init_sequencer
   import sdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_response_byte,
   input  logic [7:0]  req_ocr_first_byte,
   input  logic        req_ocr_timeout,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_finished,
   output logic [7:0]  rsp_command_byte,
   output logic [31:0] rsp_argument,
   output logic [7:0]  rsp_crc_byte,
   output logic [3:0]  rsp_status,
   output logic        rsp_card_v2,
   output logic        rsp_card_hc,
   output logic        rsp_high_speed
);

   logic             in_valid_ff, in_valid_in;
   sdi_item_type     item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_finished_ff;
   logic [7:0]       rsp_command_byte_ff;
   logic [31:0]      rsp_argument_ff;
   logic [7:0]       rsp_crc_byte_ff;
   logic [3:0]       rsp_status_ff;
   logic             rsp_card_v2_ff;
   logic             rsp_card_hc_ff;
   logic             rsp_high_speed_ff;

   logic             req_accept;
   logic             fire;
   sdi_decision_type decision;
   sdi_frame_type    frame;

   // The held transfer moves on when the result register is free or draining.
   assign fire       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   sdi_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .item_fire (fire),
      .item      (item_ff),
      .decision  (decision)
   );

   assign frame = frame_fields(decision.frame);

   // Valid flags of the input and result registers.
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (fire) begin
         rsp_valid_in = decision.emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.command        <= req_command;
         item_ff.response_byte  <= req_response_byte;
         item_ff.ocr_first_byte <= req_ocr_first_byte;
         item_ff.ocr_timeout    <= req_ocr_timeout;
      end
   end

   // Result register payload; frame fields read zero in a final status.
   always_ff @(posedge clock) begin
      if (fire && decision.emit) begin
         rsp_finished_ff     <= decision.finished;
         rsp_command_byte_ff <= decision.finished ? 8'h00 : frame.command_byte;
         rsp_argument_ff     <= decision.finished ? 32'h0 : frame.argument;
         rsp_crc_byte_ff     <= decision.finished ? 8'h00 : frame.crc_byte;
         rsp_status_ff       <= decision.finished ? decision.status : ST_OK;
         rsp_card_v2_ff      <= decision.card_v2;
         rsp_card_hc_ff      <= decision.card_hc;
         rsp_high_speed_ff   <= decision.finished && (decision.status == ST_OK);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_finished     = rsp_finished_ff;
   assign rsp_command_byte = rsp_command_byte_ff;
   assign rsp_argument     = rsp_argument_ff;
   assign rsp_crc_byte     = rsp_crc_byte_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_card_v2      = rsp_card_v2_ff;
   assign rsp_card_hc      = rsp_card_hc_ff;
   assign rsp_high_speed   = rsp_high_speed_ff;

   // A result held under stall is never overwritten by a new decision.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !fire)
      else $error("held input moved while the result register was stalled");

   // A stalled result stays valid until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled result was dropped");

   // High speed is only signaled for a successful final status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_high_speed_ff |-> rsp_finished_ff && rsp_status_ff == ST_OK)
      else $error("high speed flagged without a successful end");

endmodule

// ===== tb/sv/sd_spi_card_init_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// SD card SPI init sequencer testbench
// Drives start and card-response transfers into the sequencer, predicts each
// command frame or final status with an independent model of the sequence,
// and checks every result transfer in order. Directed cases come first, then
// both retry loops run to their limit, then random card behavior follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sd_spi_card_init_sequencer_test
   import sdi_pkg::*;
();

   // Request kinds on the input channel.
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_RESPONSE = 1'b1;

   // Command bytes with start bits, and the non-zero arguments.
   localparam logic [7:0]  CMD_GO_IDLE     = 8'h40;
   localparam logic [7:0]  CMD_SEND_OP     = 8'h41;
   localparam logic [7:0]  CMD_IF_COND     = 8'h48;
   localparam logic [7:0]  CMD_APP_OP_COND = 8'h69;
   localparam logic [7:0]  CMD_APP         = 8'h77;
   localparam logic [7:0]  CMD_READ_OCR    = 8'h7A;
   localparam logic [31:0] ARG_NONE        = 32'h0000_0000;
   localparam logic [31:0] ARG_IF_COND     = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS         = 32'h4030_0000;
   localparam logic [7:0]  READ_OCR_CRC    = 8'hFF;

   // R1 answers that steer the sequence.
   localparam logic [7:0] R1_READY   = 8'h00;
   localparam logic [7:0] R1_IDLE    = 8'h01;
   localparam logic [7:0] R1_ILLEGAL = 8'h05;
   localparam logic [7:0] R1_NONE    = 8'hFF;

   // Steps of the initialization sequence: which answer is awaited.
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_GO_IDLE,
      STEP_IF_COND,
      STEP_V2_APP,
      STEP_V2_OP_COND,
      STEP_V2_READ_OCR,
      STEP_V1_APP_FIRST,
      STEP_V1_OP_COND_FIRST,
      STEP_V1_APP,
      STEP_V1_OP_COND,
      STEP_V1_MMC_INIT
   } init_step_type;

   // One result transfer as seen on the rsp_ ports.
   typedef struct packed {
      logic        finished;
      logic [7:0]  command_byte;
      logic [31:0] argument;
      logic [7:0]  crc_byte;
      logic [3:0]  status;
      logic        card_v2;
      logic        card_hc;
      logic        high_speed;
   } init_reply_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [7:0]  req_response_byte;
   logic [7:0]  req_ocr_first_byte;
   logic        req_ocr_timeout;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_finished;
   logic [7:0]  rsp_command_byte;
   logic [31:0] rsp_argument;
   logic [7:0]  rsp_crc_byte;
   logic [3:0]  rsp_status;
   logic        rsp_card_v2;
   logic        rsp_card_hc;
   logic        rsp_high_speed;

   // Predicted sequencer state and the replies still to come.
   init_step_type  step;
   int             pass_count;
   int             go_idle_tries;
   logic [7:0]     latest_r1;
   logic           kind_v2;
   logic           kind_hc;
   init_reply_type expected_replies[$];

   int error_count;
   int tx_gap_max;
   int rx_stall_max;

   sd_spi_card_init_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_response_byte  (req_response_byte),
      .req_ocr_first_byte (req_ocr_first_byte),
      .req_ocr_timeout    (req_ocr_timeout),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_finished       (rsp_finished),
      .rsp_command_byte   (rsp_command_byte),
      .rsp_argument       (rsp_argument),
      .rsp_crc_byte       (rsp_crc_byte),
      .rsp_status         (rsp_status),
      .rsp_card_v2        (rsp_card_v2),
      .rsp_card_hc        (rsp_card_hc),
      .rsp_high_speed     (rsp_high_speed)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("sd_spi_card_init_sequencer_test: errors");
      $finish;
   end

   // CRC7 (x^7 + x^3 + 1) over the command byte and argument, one bit at a
   // time, returned in the frame's last byte with the end bit set.
   function automatic logic [7:0] frame_crc(input logic [7:0] cmd, input logic [31:0] arg);
      logic [39:0] bits;
      logic [6:0]  crc;
      logic        feedback;
      bits = {cmd, arg};
      crc  = '0;
      for (int i = 39; i >= 0; i--) begin
         feedback = bits[i] ^ crc[6];
         crc      = {crc[5:0], 1'b0} ^ (feedback ? 7'h09 : 7'h00);
      end
      return {crc, 1'b1};
   endfunction

   // Expect a command frame and move on to the step that awaits its answer.
   function automatic void expect_frame(input logic [7:0] cmd, input logic [31:0] arg,
                                        input bit fixed_crc, input init_step_type next_step);
      init_reply_type r;
      r              = '0;
      r.command_byte = cmd;
      r.argument     = arg;
      r.crc_byte     = fixed_crc ? READ_OCR_CRC : frame_crc(cmd, arg);
      r.card_v2      = kind_v2;
      r.card_hc      = kind_hc;
      expected_replies.push_back(r);
      step = next_step;
   endfunction

   // Expect the final status; the sequence goes back to idle.
   function automatic void expect_status(input logic [3:0] code);
      init_reply_type r;
      r            = '0;
      r.finished   = 1'b1;
      r.status     = code;
      r.card_v2    = kind_v2;
      r.card_hc    = kind_hc;
      r.high_speed = (code == ST_OK);
      expected_replies.push_back(r);
      step = STEP_IDLE;
   endfunction

   // A loop pass that did not finish: count it, give up or start another.
   function automatic void expect_next_pass(input bit v2_loop);
      pass_count++;
      if (pass_count >= RETRY_LIMIT) begin
         expect_status(v2_loop ? ST_V2_TIMEOUT : ST_V1_TIMEOUT);
      end else if (v2_loop) begin
         expect_frame(CMD_APP, ARG_NONE, 1'b0, STEP_V2_APP);
      end else if (latest_r1 == R1_READY) begin
         expect_frame(CMD_APP, ARG_NONE, 1'b0, STEP_V1_APP);
      end else begin
         expect_frame(CMD_SEND_OP, ARG_NONE, 1'b0, STEP_V1_MMC_INIT);
      end
   endfunction

   // Advance the predicted sequence by one accepted transfer.
   function automatic void predict_init_step(input logic cmd, input logic [7:0] r1,
                                             input logic [7:0] ocr, input logic ocr_tmo);
      if (cmd == REQ_START) begin
         kind_v2       = 1'b0;
         kind_hc       = 1'b0;
         pass_count    = 0;
         latest_r1     = R1_READY;
         go_idle_tries = 1;
         expect_frame(CMD_GO_IDLE, ARG_NONE, 1'b0, STEP_GO_IDLE);
         return;
      end
      case (step)
         STEP_GO_IDLE: begin
            if (r1 == R1_IDLE || go_idle_tries >= 2) begin
               expect_frame(CMD_IF_COND, ARG_IF_COND, 1'b0, STEP_IF_COND);
            end else begin
               go_idle_tries = 2;
               expect_frame(CMD_GO_IDLE, ARG_NONE, 1'b0, STEP_GO_IDLE);
            end
         end
         STEP_IF_COND: begin
            if (r1 == R1_NONE) begin
               expect_status(ST_CMD8_NO_ANS);
            end else begin
               pass_count = 0;
               if (r1 != R1_ILLEGAL) begin
                  kind_v2 = 1'b1;
                  expect_frame(CMD_APP, ARG_NONE, 1'b0, STEP_V2_APP);
               end else begin
                  expect_frame(CMD_APP, ARG_NONE, 1'b0, STEP_V1_APP_FIRST);
               end
            end
         end
         STEP_V2_APP: begin
            if (r1 == R1_NONE) expect_status(ST_V2_CMD55_NO);
            else if (r1 != R1_IDLE) expect_next_pass(1'b1);
            else expect_frame(CMD_APP_OP_COND, ARG_HCS, 1'b0, STEP_V2_OP_COND);
         end
         STEP_V2_OP_COND: begin
            if (r1 == R1_NONE) expect_status(ST_V2_ACMD41_NO);
            else if (r1 != R1_READY) expect_next_pass(1'b1);
            else expect_frame(CMD_READ_OCR, ARG_NONE, 1'b1, STEP_V2_READ_OCR);
         end
         STEP_V2_READ_OCR: begin
            // Only the OCR matters here, the R1 byte is not looked at.
            if (ocr_tmo) begin
               expect_status(ST_OCR_TIMEOUT);
            end else begin
               if (ocr[6]) kind_hc = 1'b1;
               expect_status(ST_OK);
            end
         end
         STEP_V1_APP_FIRST: begin
            if (r1 == R1_NONE) expect_status(ST_V1_CMD55A_NO);
            else expect_frame(CMD_APP_OP_COND, ARG_NONE, 1'b0, STEP_V1_OP_COND_FIRST);
         end
         STEP_V1_OP_COND_FIRST: begin
            if (r1 == R1_NONE) begin
               expect_status(ST_V1_ACMD41A_NO);
            end else begin
               latest_r1  = r1;
               pass_count = 0;
               if (r1 == R1_READY) expect_frame(CMD_APP, ARG_NONE, 1'b0, STEP_V1_APP);
               else expect_frame(CMD_SEND_OP, ARG_NONE, 1'b0, STEP_V1_MMC_INIT);
            end
         end
         STEP_V1_APP: begin
            if (r1 == R1_NONE) begin
               expect_status(ST_V1_CMD55_NO);
            end else begin
               latest_r1 = r1;
               if (r1 != R1_IDLE) expect_next_pass(1'b0);
               else expect_frame(CMD_APP_OP_COND, ARG_NONE, 1'b0, STEP_V1_OP_COND);
            end
         end
         STEP_V1_OP_COND: begin
            if (r1 == R1_NONE) begin
               expect_status(ST_V1_ACMD41_NO);
            end else begin
               latest_r1 = r1;
               if (r1 != R1_READY) expect_next_pass(1'b0);
               else expect_status(ST_OK);
            end
         end
         STEP_V1_MMC_INIT: begin
            latest_r1 = r1;
            if (r1 != R1_READY) expect_next_pass(1'b0);
            else expect_status(ST_OK);
         end
         default: begin
            // A response while no sequence runs is dropped.
         end
      endcase
   endfunction

   // Send one transfer after a random gap and predict it once accepted.
   // Called right after a rising edge.
   task automatic send_item(input logic cmd, input logic [7:0] r1,
                            input logic [7:0] ocr, input logic ocr_tmo);
      int unsigned gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_response_byte  <= r1;
      req_ocr_first_byte <= ocr;
      req_ocr_timeout    <= ocr_tmo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_init_step(cmd, r1, ocr, ocr_tmo);
   endtask

   // Answer a healthy but not always ready card would give at this step.
   function automatic logic [7:0] willing_answer();
      case (step)
         STEP_GO_IDLE, STEP_V2_APP, STEP_V1_APP_FIRST, STEP_V1_APP:
            return R1_IDLE;
         STEP_IF_COND:
            return $urandom_range(0, 1) ? R1_IDLE : R1_ILLEGAL;
         STEP_V1_OP_COND_FIRST:
            return $urandom_range(0, 1) ? R1_READY : R1_ILLEGAL;
         default:
            return $urandom_range(0, 1) ? R1_READY : R1_IDLE;
      endcase
   endfunction

   // One random turn: a start, a card answer, or now and then noise.
   task automatic random_card_turn(output bit counted);
      logic [7:0]  r1;
      logic [7:0]  ocr;
      logic        ocr_tmo;
      int unsigned roll;
      r1      = 8'($urandom_range(0, 255));
      ocr     = 8'($urandom_range(0, 255));
      ocr_tmo = 1'($urandom_range(0, 1));
      roll    = $urandom_range(0, 99);
      counted = 1'b1;
      if (step == STEP_IDLE) begin
         if (roll < 85) begin
            send_item(REQ_START, r1, ocr, ocr_tmo);
         end else begin
            counted = 1'b0;
            send_item(REQ_RESPONSE, r1, ocr, ocr_tmo);
         end
      end else if (roll < 3) begin
         send_item(REQ_START, r1, ocr, ocr_tmo);
      end else begin
         if (roll < 75) r1 = willing_answer();
         else if (roll < 85) r1 = R1_NONE;
         if (step == STEP_V2_READ_OCR) ocr_tmo = ($urandom_range(0, 7) == 0);
         send_item(REQ_RESPONSE, r1, ocr, ocr_tmo);
      end
   endtask

   // Responses with no sequence running produce nothing.
   task automatic test_response_while_idle();
      send_item(REQ_RESPONSE, R1_READY, 8'hFF, 1'b1);
      send_item(REQ_RESPONSE, R1_NONE, 8'h00, 1'b0);
   endtask

   // Version-2 card that reports high capacity; the R1 of CMD58 is ignored.
   task automatic test_v2_high_capacity();
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, 8'hAA, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_NONE, 8'hFF, 1'b0);
   endtask

   // CMD0 twice with wrong answers, then a version-1 card through ACMD41.
   task automatic test_v1_after_go_idle_retry();
      send_item(REQ_START, R1_NONE, 8'hFF, 1'b1);
      send_item(REQ_RESPONSE, R1_NONE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_ILLEGAL, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
   endtask

   // A start in mid-sequence restarts it; then CMD8 gets no answer.
   task automatic test_restart_and_no_if_cond_answer();
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_NONE, 8'h00, 1'b0);
   endtask

   // Version-1 card that rejects ACMD41 and comes up through CMD1.
   task automatic test_v1_mmc_fallback();
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_ILLEGAL, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, 8'h04, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_READY, 8'h00, 1'b0);
   endtask

   // Both loops kept busy until they run out of passes, back to back.
   task automatic test_retry_limits();
      logic [7:0] busy;
      tx_gap_max   = 0;
      rx_stall_max = 0;
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      while (step != STEP_IDLE) begin
         if (step == STEP_V2_APP && $urandom_range(0, 1)) busy = R1_IDLE;
         else if (step == STEP_V2_APP) busy = 8'($urandom_range(2, 254));
         else busy = 8'($urandom_range(1, 254));
         send_item(REQ_RESPONSE, busy, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_item(REQ_START, R1_READY, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_ILLEGAL, 8'h00, 1'b0);
      send_item(REQ_RESPONSE, R1_IDLE, 8'h00, 1'b0);
      while (step != STEP_IDLE) begin
         busy = 8'($urandom_range(1, 254));
         send_item(REQ_RESPONSE, busy, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   // Mostly well-behaved cards with random content, some noise and restarts.
   task automatic test_random_sequences();
      int done;
      bit counted;
      done = 0;
      while (done < 1500) begin
         if (done % 150 == 0) begin
            tx_gap_max   = $urandom_range(0, 1) ? 11 : 0;
            rx_stall_max = $urandom_range(0, 1) ? 11 : 0;
         end
         random_card_turn(counted);
         if (counted) done++;
      end
   endtask

   // Result side: after each transfer, hold off for a random number of cycles.
   initial begin : result_pacing
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) hold_left = $urandom_range(0, rx_stall_max);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every result transfer with the oldest expected reply.
   always @(posedge clock) begin : reply_check
      init_reply_type got;
      init_reply_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = '{rsp_finished, rsp_command_byte, rsp_argument, rsp_crc_byte,
                 rsp_status, rsp_card_v2, rsp_card_hc, rsp_high_speed};
         if (expected_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected: fin=%0d cmd=%h arg=%h crc=%h st=%0d v2=%0d hc=%0d hs=%0d",
                        got.finished, got.command_byte, got.argument, got.crc_byte,
                        got.status, got.card_v2, got.card_hc, got.high_speed);
         end else begin
            want = expected_replies.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("exp: fin=%0d cmd=%h arg=%h crc=%h st=%0d v2=%0d hc=%0d hs=%0d",
                           want.finished, want.command_byte, want.argument, want.crc_byte,
                           want.status, want.card_v2, want.card_hc, want.high_speed);
                  $display("got: fin=%0d cmd=%h arg=%h crc=%h st=%0d v2=%0d hc=%0d hs=%0d",
                           got.finished, got.command_byte, got.argument, got.crc_byte,
                           got.status, got.card_v2, got.card_hc, got.high_speed);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      error_count        = 0;
      tx_gap_max         = 11;
      rx_stall_max       = 11;
      step               = STEP_IDLE;
      pass_count         = 0;
      go_idle_tries      = 0;
      latest_r1          = R1_READY;
      kind_v2            = 1'b0;
      kind_hc            = 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_command        <= REQ_START;
      req_response_byte  <= 8'h00;
      req_ocr_first_byte <= 8'h00;
      req_ocr_timeout    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_response_while_idle();
      test_v2_high_capacity();
      test_v1_after_go_idle_retry();
      test_restart_and_no_if_cond_answer();
      test_v1_mmc_fallback();
      test_retry_limits();
      test_random_sequences();

      // Let the last replies come out, then keep watching for strays.
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("sd_spi_card_init_sequencer_test: clean");
      end else begin
         $display("sd_spi_card_init_sequencer_test: errors");
      end
      $finish;
   end

endmodule

// ===== sd_spi_card_init_sequencer.f =====
src/sdi_pkg.sv
src/sdi_fsm.sv
src/sd_spi_card_init_sequencer.sv
tb/sv/sd_spi_card_init_sequencer_test.sv
